/* sv/ltp_pkg.sv */
`timescale 1ns / 1ps

package ltp_pkg;

	localparam int MAX_THREADS = 16;
	localparam int TICKET_BITS = 16;
	localparam int IDX_W       = $clog2(MAX_THREADS);
	localparam int CNT_W       = $clog2(MAX_THREADS + 1);
	localparam int CFG_W       = 5;
	localparam int SUM_W       = 20;
	localparam int ALU_W       = SUM_W + 1;
	localparam int RND_W       = 32;
	localparam int BIT_W       = $clog2(RND_W);

	localparam logic [1:0] KIND_LOAD     = 2'd0;
	localparam logic [1:0] KIND_DRAW     = 2'd1;
	localparam logic [1:0] KIND_COMPLETE = 2'd2;

	typedef struct packed {
		logic [1:0]             kind;
		logic [3:0]             thread_index;
		logic [TICKET_BITS-1:0] ticket_count;
		logic [RND_W-1:0]       random_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]       picked_thread;
		logic             picked_valid;
		logic             all_done;
		logic [SUM_W-1:0] tickets_in_play;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MOD,
		ST_WALK,
		ST_OUT
	} ltp_state_t;

endpackage

/* sv/lottery_thread_picker.sv */
`timescale 1ns / 1ps

// Channel   Direction  Signals                        Item
// in        in         in_valid, in_ready, in_data    in_item_t: load, draw or complete
// out       out        out_valid, out_ready, out_data out_item_t: pick and status
// cfg       in         cfg_valid, cfg_ready, cfg_data threads_in_use (always ready)
//
// Sequence: the sequencer and its one shared 21-bit add/subtract unit take each input
//   item in turn through a ticket-table pass, a bit-serial modulo of one bit a cycle,
//   and a second table pass for the pick; the modulo and the second pass run only for
//   a draw that picks.
// Reset: arst_n clears the ticket table, the completion marks, the current thread,
//   the output slot and sets threads_in_use to 16.
// Stalls: in_ready is high only while the sequencer is idle; a finished item sits in
//   the output register, so the next item may be accepted while out_ready is low.

module lottery_thread_picker
	import ltp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	// state of the lottery
	logic [TICKET_BITS-1:0] table_q [MAX_THREADS];
	logic [MAX_THREADS-1:0] done_q;
	logic [IDX_W-1:0]       run_thread_q;
	logic                   run_valid_q;
	logic [CFG_W-1:0]       cfg_q;

	// sequencer and working registers
	ltp_state_t       state_q, state_d;
	in_item_t         item_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] dtot_q;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] rem_q;
	logic [RND_W-1:0] rnd_q;
	logic [BIT_W-1:0] bit_q;
	logic             found_q;
	logic [IDX_W-1:0] pick_q;

	// output slot
	logic      out_valid_q;
	out_item_t out_q;

	// shared arithmetic unit
	logic [ALU_W-1:0] alu_a, alu_b;
	logic             alu_sub;
	logic [ALU_W:0]   alu_res;
	logic             alu_borrow;

	logic [CNT_W-1:0]       n_act;
	logic [IDX_W-1:0]       idx;
	logic [TICKET_BITS-1:0] ticket_rd;
	logic                   done_rd;
	logic                   walk_end;
	logic                   is_draw;
	logic                   start_mod;
	logic                   out_free;
	logic                   accept;

	// Clamp the register: zero acts as one, anything above the table acts as full.
	always_comb begin
		if (cfg_q == '0) begin
			n_act = CNT_W'(1);
		end else if (cfg_q > CFG_W'(MAX_THREADS)) begin
			n_act = CNT_W'(MAX_THREADS);
		end else begin
			n_act = CNT_W'(cfg_q);
		end
	end

	assign idx       = cnt_q[IDX_W-1:0];
	assign ticket_rd = table_q[idx];
	assign done_rd   = done_q[idx];
	assign walk_end  = (cnt_q == n_act);
	assign is_draw   = (item_q.kind == KIND_DRAW) || (item_q.kind == KIND_COMPLETE);
	// Draw only with threads left and tickets in play; never take a modulo by zero.
	assign start_mod = is_draw && (dtot_q != n_act) && (acc_q != '0);
	assign out_free  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SUM;
			end
			ST_SUM: begin
				if (walk_end) state_d = start_mod ? ST_MOD : ST_OUT;
			end
			ST_MOD: begin
				if (bit_q == BIT_W'(RND_W - 1)) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_end || (!done_rd && alu_borrow)) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshakes and the operands of the shared unit
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
		alu_a     = {1'b0, acc_q};
		alu_b     = ALU_W'(ticket_rd);
		alu_sub   = 1'b0;
		unique case (state_q)
			ST_MOD: begin
				// shift in the next dividend bit, trial-subtract the tickets in play
				alu_a   = {rem_q, rnd_q[RND_W-1]};
				alu_b   = {1'b0, acc_q};
				alu_sub = 1'b1;
			end
			ST_WALK: begin
				// borrow means this thread's tickets cover what is left of the target
				alu_a   = {1'b0, rem_q};
				alu_b   = ALU_W'(ticket_rd);
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                            : ({1'b0, alu_a} + {1'b0, alu_b});
	assign alu_borrow = alu_res[ALU_W];

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			for (int i = 0; i < MAX_THREADS; i++) table_q[i] <= '0;
			done_q       <= '0;
			run_thread_q <= '0;
			run_valid_q  <= 1'b0;
			cfg_q        <= CFG_W'(16);
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) cfg_q <= cfg_data;

			if (accept) begin
				if (in_data.kind == KIND_LOAD) begin
					table_q[in_data.thread_index[IDX_W-1:0]] <= in_data.ticket_count;
					done_q[in_data.thread_index[IDX_W-1:0]]  <= 1'b0;
				end else if (in_data.kind == KIND_COMPLETE && run_valid_q &&
				             (CNT_W'(run_thread_q) < n_act)) begin
					// retire the current thread before the draw
					done_q[run_thread_q] <= 1'b1;
				end
			end

			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				if (is_draw) begin
					run_valid_q <= found_q;
					if (found_q) run_thread_q <= pick_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q  <= in_data;
					cnt_q   <= '0;
					dtot_q  <= '0;
					acc_q   <= '0;
					found_q <= 1'b0;
					pick_q  <= '0;
				end
			end
			ST_SUM: begin
				if (!walk_end) begin
					if (done_rd) dtot_q <= dtot_q + CNT_W'(1);
					else acc_q <= alu_res[SUM_W-1:0];
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					rem_q <= '0;
					bit_q <= '0;
					rnd_q <= item_q.random_value;
					cnt_q <= '0;
				end
			end
			ST_MOD: begin
				// restoring step: keep the difference unless it went negative
				rem_q <= alu_borrow ? alu_a[SUM_W-1:0] : alu_res[SUM_W-1:0];
				rnd_q <= {rnd_q[RND_W-2:0], 1'b0};
				bit_q <= bit_q + BIT_W'(1);
			end
			ST_WALK: begin
				if (!walk_end) begin
					if (!done_rd) begin
						if (alu_borrow) begin
							found_q <= 1'b1;
							pick_q  <= idx;
						end else begin
							rem_q <= alu_res[SUM_W-1:0];
						end
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_q.picked_thread   <= found_q ? 4'(pick_q) : 4'd0;
					out_q.picked_valid    <= found_q;
					out_q.all_done        <= (dtot_q == n_act);
					// sixteen entries of sixteen bits never exceed the 20-bit limit
					out_q.tickets_in_play <= acc_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_accept_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SUM)
		else $error("accepted item did not start the ticket pass");

	a_done_within_pass: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM |-> dtot_q <= cnt_q)
		else $error("completed count ran ahead of the pass");

	a_target_below_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> rem_q < acc_q)
		else $error("draw target not below tickets in play");

	a_pick_unfinished: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && found_q) |-> !done_q[pick_q])
		else $error("picked a completed thread");

	a_pick_not_all_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.picked_valid && out_q.all_done))
		else $error("pick reported with every thread done");
`endif

endmodule
